/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/i2cra_pkg.sv */
// ----------------------------------------------------------------------------
// I2C register access package
// Request codes, transaction program tables and sizes for the I2C master.
// ----------------------------------------------------------------------------
package i2cra_pkg;

  // Request kinds carried on the input stream.
  typedef logic [1:0] req_t;
  localparam req_t REQ_TICK  = 2'd0;
  localparam req_t REQ_WRITE = 2'd1;
  localparam req_t REQ_READB = 2'd2;
  localparam req_t REQ_READW = 2'd3;

  // Bus operations of one program step.
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE  = 3'd0;
  localparam op_t OP_START = 3'd1;
  localparam op_t OP_TX    = 3'd2;
  localparam op_t OP_RX    = 3'd3;
  localparam op_t OP_NAK   = 3'd4;
  localparam op_t OP_STOP  = 3'd5;

  // Source of a transmitted byte.
  typedef logic [2:0] src_t;
  localparam src_t SRC_NONE = 3'd0;
  localparam src_t SRC_AW   = 3'd1;
  localparam src_t SRC_AR   = 3'd2;
  localparam src_t SRC_REG  = 3'd3;
  localparam src_t SRC_REG1 = 3'd4;
  localparam src_t SRC_DATA = 3'd5;

  // Step counter: programs run at most sixteen steps.
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t WR_LEN   = 5'd5;
  localparam step_t RDB_LEN  = 5'd8;
  localparam step_t RDW_LEN  = 5'd16;
  localparam step_t RD_SPLIT = 5'd8;

  // Bits per byte and bit counter.
  typedef logic [3:0] bitcnt_t;
  localparam bitcnt_t BYTE_BITS = 4'd8;

  localparam logic [7:0] SLAVE_ADDR_RESET = 8'd208;

  // Program length of a request kind.
  function automatic step_t prog_len(input req_t t);
    step_t len;
    unique case (t)
      REQ_WRITE: len = WR_LEN;
      REQ_READB: len = RDB_LEN;
      REQ_READW: len = RDW_LEN;
      default:   len = '0;
    endcase
    return len;
  endfunction

  // Write program: START, address, register, data, STOP.
  function automatic op_t wr_op(input logic [2:0] idx);
    op_t op;
    unique case (idx)
      3'd0:    op = OP_START;
      3'd1:    op = OP_TX;
      3'd2:    op = OP_TX;
      3'd3:    op = OP_TX;
      3'd4:    op = OP_STOP;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic src_t wr_src(input logic [2:0] idx);
    src_t src;
    unique case (idx)
      3'd1:    src = SRC_AW;
      3'd2:    src = SRC_REG;
      3'd3:    src = SRC_DATA;
      default: src = SRC_NONE;
    endcase
    return src;
  endfunction

  // Byte read program: START, address, register, START, read address,
  // receive, NAK, STOP.
  function automatic op_t rd_op(input logic [2:0] idx);
    op_t op;
    unique case (idx)
      3'd0: op = OP_START;
      3'd1: op = OP_TX;
      3'd2: op = OP_TX;
      3'd3: op = OP_START;
      3'd4: op = OP_TX;
      3'd5: op = OP_RX;
      3'd6: op = OP_NAK;
      3'd7: op = OP_STOP;
    endcase
    return op;
  endfunction

  function automatic src_t rd_src(input logic [2:0] idx);
    src_t src;
    unique case (idx)
      3'd1:    src = SRC_AW;
      3'd2:    src = SRC_REG;
      3'd4:    src = SRC_AR;
      default: src = SRC_NONE;
    endcase
    return src;
  endfunction

endpackage

/* rtl/core/i2c_master_register_access_core.sv */
// ----------------------------------------------------------------------------
// I2C master register access core
// Tick-driven I2C master that runs register writes, byte reads and word reads.
// ----------------------------------------------------------------------------
// Each input item is one bus tick and yields exactly one result item holding
// the SCL and SDA levels for that tick, busy and done flags and the last read
// value. The block takes one item per clock cycle while the result stream
// does not stall; an item passes an input register and the sequencer's
// one-step next-state logic into a result register, from which its result
// can be taken. A request seen while idle starts its transaction on that
// same tick; requests seen while busy are ignored. Bits take two ticks,
// START and STOP three each, and slave acknowledges are not checked. The
// slave address register may be written only while no items are in flight.
`include "assert_macros.svh"

module i2c_master_register_access_core (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,  // reg_sel[7:0], write_data[15:8], sda_in[16]
  input  i2cra_pkg::req_t      in_tuser,  // req_type[1:0]
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata, // scl[0], sda_out[1], busy_res[2], done_res[3],
                                          // read_data[19:4]
  // Slave address register.
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data
);
  import i2cra_pkg::*;

  // Configuration.
  logic [7:0] slave_addr_r;

  // Input register.
  logic       in_valid_r;
  req_t       in_req_r;
  logic [7:0] in_reg_r;
  logic [7:0] in_data_r;
  logic       in_sda_r;

  // Sequencer state.
  step_t      step_r, step_nxt;
  bitcnt_t    bc_r, bc_nxt;
  logic       hp_r, hp_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] high_r, high_nxt;
  req_t       lat_req_r, lat_req_nxt;
  logic [7:0] lat_reg_r, lat_reg_nxt;
  logic [7:0] lat_data_r, lat_data_nxt;
  logic [15:0] last_r, last_nxt;

  // Result register.
  logic              out_valid_r;
  logic              out_scl_r, out_sda_r, out_busy_r, out_done_r;
  logic signed [15:0] out_rd_r;

  // Combinational step results.
  logic       proc;
  logic       start;
  logic       scl_c, sda_c, busy_c, done_c;

  // An item moves on when the result slot is free or being drained.
  assign proc      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc;

  // Slave address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RESET;
    end else if (cfg_wr_en) begin
      slave_addr_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r  <= in_tuser;
      in_reg_r  <= in_tdata[7:0];
      in_data_r <= in_tdata[15:8];
      in_sda_r  <= in_tdata[16];
    end
  end

  // One sequencer step for the item in the input register.
  always_comb begin
    req_t       t_c;
    logic [7:0] reg_c;
    logic [7:0] data_c;
    step_t      step_c, len_c, idx_c, step_inc;
    bitcnt_t    bc_c;
    logic       hp_c;
    logic       active;
    logic       adv;
    op_t        op_c;
    src_t       src_c;
    logic [7:0] tx_v, shift_v;

    start = (step_r == '0) && (in_req_r != REQ_TICK);

    lat_req_nxt  = start ? in_req_r  : lat_req_r;
    lat_reg_nxt  = start ? in_reg_r  : lat_reg_r;
    lat_data_nxt = start ? in_data_r : lat_data_r;
    step_c       = start ? step_t'(1) : step_r;
    bc_c         = start ? '0 : bc_r;
    hp_c         = start ? 1'b0 : hp_r;

    t_c    = lat_req_nxt;
    reg_c  = lat_reg_nxt;
    data_c = lat_data_nxt;
    len_c  = prog_len(t_c);
    active = (step_c != '0) && (step_c <= len_c);
    idx_c  = step_c - step_t'(1);

    // Program lookup.
    op_c  = OP_NONE;
    src_c = SRC_NONE;
    if (active) begin
      if (t_c == REQ_WRITE) begin
        op_c  = wr_op(idx_c[2:0]);
        src_c = wr_src(idx_c[2:0]);
      end else begin
        op_c  = rd_op(idx_c[2:0]);
        src_c = rd_src(idx_c[2:0]);
        if (src_c == SRC_REG && step_c > RD_SPLIT) begin
          src_c = SRC_REG1;
        end
      end
    end

    // Defaults: idle lines, state held.
    scl_c     = 1'b1;
    sda_c     = 1'b1;
    busy_c    = 1'b0;
    done_c    = 1'b0;
    adv       = 1'b0;
    step_nxt  = active ? step_c : '0;
    bc_nxt    = bc_c;
    hp_nxt    = hp_c;
    shift_nxt = shift_r;
    high_nxt  = high_r;
    last_nxt  = last_r;

    // Byte to send at the start of a transmit step.
    unique case (src_c)
      SRC_AW:   tx_v = slave_addr_r;
      SRC_AR:   tx_v = slave_addr_r + 8'd1;
      SRC_REG:  tx_v = reg_c;
      SRC_REG1: tx_v = reg_c + 8'd1;
      default:  tx_v = data_c;
    endcase
    shift_v = (bc_c == '0 && !hp_c) ? tx_v : shift_r;

    if (op_c != OP_NONE) begin
      busy_c = 1'b1;
    end

    unique case (op_c)
      OP_START, OP_STOP: begin
        // Three ticks: SCL low, SCL high, then the SDA edge.
        scl_c = (bc_c != '0);
        if (bc_c < bitcnt_t'(2)) begin
          sda_c  = (op_c == OP_START);
          bc_nxt = bc_c + bitcnt_t'(1);
        end else begin
          sda_c = (op_c == OP_STOP);
          adv   = 1'b1;
          if (op_c == OP_STOP) begin
            if (t_c == REQ_READB) begin
              last_nxt = {8'd0, shift_r};
            end else if (t_c == REQ_READW && step_c == RD_SPLIT) begin
              high_nxt = shift_r;
            end else if (t_c == REQ_READW) begin
              last_nxt = {high_r, shift_r};
            end
            done_c = (step_c >= len_c);
          end
        end
      end
      OP_TX: begin
        scl_c = hp_c;
        if (bc_c < BYTE_BITS) begin
          sda_c = shift_v[7];
          if (hp_c) begin
            shift_nxt = {shift_v[6:0], 1'b0};
            bc_nxt    = bc_c + bitcnt_t'(1);
            hp_nxt    = 1'b0;
          end else begin
            shift_nxt = shift_v;
            hp_nxt    = 1'b1;
          end
        end else begin
          // Acknowledge slot: released and ignored.
          adv    = hp_c;
          hp_nxt = 1'b1;
        end
      end
      OP_RX: begin
        scl_c = hp_c;
        if (hp_c) begin
          shift_nxt = {shift_r[6:0], in_sda_r};
          bc_nxt    = bc_c + bitcnt_t'(1);
          hp_nxt    = 1'b0;
          adv       = (bc_c >= BYTE_BITS - bitcnt_t'(1));
        end else begin
          hp_nxt = 1'b1;
        end
      end
      OP_NAK: begin
        scl_c  = hp_c;
        adv    = hp_c;
        hp_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    // Move to the next program step, or back to idle after the last one.
    step_inc = step_c + step_t'(1);
    if (adv) begin
      step_nxt = (step_inc > len_c) ? '0 : step_inc;
      bc_nxt   = '0;
      hp_nxt   = 1'b0;
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      bc_r       <= '0;
      hp_r       <= 1'b0;
      shift_r    <= '0;
      high_r     <= '0;
      lat_req_r  <= REQ_TICK;
      lat_reg_r  <= '0;
      lat_data_r <= '0;
      last_r     <= '0;
    end else if (proc) begin
      step_r     <= step_nxt;
      bc_r       <= bc_nxt;
      hp_r       <= hp_nxt;
      shift_r    <= shift_nxt;
      high_r     <= high_nxt;
      lat_req_r  <= lat_req_nxt;
      lat_reg_r  <= lat_reg_nxt;
      lat_data_r <= lat_data_nxt;
      last_r     <= last_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_scl_r  <= scl_c;
      out_sda_r  <= sda_c;
      out_busy_r <= busy_c;
      out_done_r <= done_c;
      out_rd_r   <= signed'(last_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_rd_r, out_done_r, out_busy_r, out_sda_r, out_scl_r};

  // Checks on the sequencer.
  `ASSERT_ALWAYS(a_step_range, clk, rst_n, step_r <= RDW_LEN, "step index beyond program")
  `ASSERT_ALWAYS(a_bit_range, clk, rst_n, bc_r <= BYTE_BITS, "bit counter beyond a byte")
  `ASSERT_IMPLY(a_done_busy, clk, rst_n, out_valid_r && out_done_r, out_busy_r, "done without busy")
  `ASSERT_NEXT(a_done_idle, clk, rst_n, proc && done_c, step_r == '0, "not idle after done")
  `ASSERT_IMPLY(a_idle_lines, clk, rst_n, proc && !busy_c, scl_c && sda_c, "idle lines not released")

endmodule

/* tb/tb_i2c_master_register_access_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register access core testbench
// Streams bus ticks into the core and checks every result item against a
// tick-by-tick model of the I2C sequencer. The model covers SCL and SDA
// levels, the busy and done flags and the read value. Directed transfers
// come first, then random and truncated transfers under three slave
// addresses. Both streams stall at random but for the last, full-rate phase.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access_core;
  import i2cra_pkg::*;

  // Levels of the SDA line that the stimulus plays back during a transfer.
  localparam int SDA_RANDOM = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_LOW    = 2;
  localparam int SDA_SPLIT  = 3;

  localparam int RANDOM_TICKS = 340;

  // One input item: a bus tick with an optional request.
  typedef struct {
    req_t       kind;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda;
  } bus_tick_t;

  // One result item: bus levels and status for a tick.
  typedef struct {
    logic        scl;
    logic        sda;
    logic        busy;
    logic        done;
    logic [15:0] rd;
  } bus_level_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // reg_sel[7:0], write_data[15:8], sda_in[16]
  req_t        in_tuser = REQ_TICK; // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // scl[0], sda_out[1], busy_res[2], done_res[3],
                                // read_data[19:4]
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  bus_tick_t   pending_ticks[$];
  bus_level_t  expected_levels[$];
  logic        in_taken = 1'b0;
  int          send_idle_pct = 29;
  int          recv_idle_pct = 80;
  int          mismatch_count = 0;
  int          ticks_checked = 0;
  int          starts_seen = 0;
  int          dones_seen = 0;

  // Sequencer model state.
  logic [7:0]  slave_wr_addr = SLAVE_ADDR_RESET;
  logic [5:0]  bus_step = '0;
  logic [3:0]  bit_cnt = '0;
  logic        half_tick = 1'b0;
  logic [7:0]  shift_reg = '0;
  logic [7:0]  high_rd = '0;
  req_t        req_kind = REQ_TICK;
  logic [7:0]  req_reg = '0;
  logic [7:0]  req_data = '0;
  logic [15:0] last_rd = '0;

  i2c_master_register_access_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Move to the next program step; past the last step the sequencer idles.
  task automatic next_step(input logic [5:0] len);
    bus_step  = bus_step + 6'd1;
    bit_cnt   = '0;
    half_tick = 1'b0;
    if (bus_step > len) bus_step = '0;
  endtask

  // Advance the sequencer model by one bus tick and return its bus levels.
  task automatic i2c_tick(input req_t kind, input logic [7:0] ra, input logic [7:0] wd,
                          input logic sda_i, output bus_level_t lv);
    logic [5:0] len;
    logic [2:0] idx;
    op_t        op;
    src_t       src;
    logic [7:0] tx_byte;
    lv.scl  = 1'b1;
    lv.sda  = 1'b1;
    lv.busy = 1'b0;
    lv.done = 1'b0;
    op      = OP_NONE;
    src     = SRC_NONE;

    // A request is latched only while idle and starts on this same tick.
    if (bus_step == '0 && kind != REQ_TICK) begin
      req_kind  = kind;
      req_reg   = ra;
      req_data  = wd;
      bus_step  = 6'd1;
      bit_cnt   = '0;
      half_tick = 1'b0;
      starts_seen++;
    end

    case (req_kind)
      REQ_WRITE: len = 6'd5;
      REQ_READB: len = 6'd8;
      REQ_READW: len = 6'd16;
      default:   len = 6'd0;
    endcase

    // Decode the operation of the current step.
    if (bus_step != '0 && bus_step <= len) begin
      idx = 3'(bus_step - 6'd1);
      if (req_kind == REQ_WRITE) begin
        case (idx)
          3'd0:    op = OP_START;
          3'd1: begin
            op  = OP_TX;
            src = SRC_AW;
          end
          3'd2: begin
            op  = OP_TX;
            src = SRC_REG;
          end
          3'd3: begin
            op  = OP_TX;
            src = SRC_DATA;
          end
          default: op = OP_STOP;
        endcase
      end else begin
        case (idx)
          3'd0: op = OP_START;
          3'd1: begin
            op  = OP_TX;
            src = SRC_AW;
          end
          3'd2: begin
            op  = OP_TX;
            src = (bus_step > 6'd8) ? SRC_REG1 : SRC_REG;
          end
          3'd3: op = OP_START;
          3'd4: begin
            op  = OP_TX;
            src = SRC_AR;
          end
          3'd5: op = OP_RX;
          3'd6: op = OP_NAK;
          default: op = OP_STOP;
        endcase
      end
    end else begin
      bus_step = '0;
    end

    if (op != OP_NONE) begin
      lv.busy = 1'b1;
      case (op)
        // START and STOP take three ticks each.
        OP_START, OP_STOP: begin
          lv.scl = (bit_cnt != 4'd0);
          lv.sda = (bit_cnt < 4'd2) ? (op == OP_START) : (op == OP_STOP);
          if (bit_cnt >= 4'd2) begin
            if (op == OP_STOP) begin
              if (req_kind == REQ_READB) last_rd = {8'h00, shift_reg};
              else if (req_kind == REQ_READW && bus_step == 6'd8) high_rd = shift_reg;
              else if (req_kind == REQ_READW) last_rd = {high_rd, shift_reg};
              if (bus_step >= len) lv.done = 1'b1;
            end
            next_step(len);
          end else begin
            bit_cnt = bit_cnt + 4'd1;
          end
        end
        // Eight data bits MSB first, then the ignored slave acknowledge.
        OP_TX: begin
          lv.scl = half_tick;
          if (bit_cnt < 4'd8) begin
            if (bit_cnt == 4'd0 && !half_tick) begin
              case (src)
                SRC_AW:   tx_byte = slave_wr_addr;
                SRC_AR:   tx_byte = slave_wr_addr + 8'd1;
                SRC_REG:  tx_byte = req_reg;
                SRC_REG1: tx_byte = req_reg + 8'd1;
                default:  tx_byte = req_data;
              endcase
              shift_reg = tx_byte;
            end
            lv.sda = shift_reg[7];
            if (half_tick) begin
              shift_reg = {shift_reg[6:0], 1'b0};
              bit_cnt   = bit_cnt + 4'd1;
              half_tick = 1'b0;
            end else begin
              half_tick = 1'b1;
            end
          end else begin
            lv.sda = 1'b1;
            if (half_tick) next_step(len);
            else half_tick = 1'b1;
          end
        end
        // Receive samples SDA while SCL is high.
        OP_RX: begin
          lv.scl = half_tick;
          lv.sda = 1'b1;
          if (half_tick) begin
            shift_reg = {shift_reg[6:0], sda_i};
            bit_cnt   = bit_cnt + 4'd1;
            half_tick = 1'b0;
            if (bit_cnt >= 4'd8) next_step(len);
          end else begin
            half_tick = 1'b1;
          end
        end
        default: begin
          lv.scl = half_tick;
          lv.sda = 1'b1;
          if (half_tick) next_step(len);
          else half_tick = 1'b1;
        end
      endcase
    end
    lv.rd = last_rd;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < 100)
      $display("%0t: result %0d field %s: got 0x%0h, expected 0x%0h",
               $realtime, ticks_checked, field, got, want);
    mismatch_count++;
  endtask

  // Ticks that a transfer of this kind occupies, request tick included.
  function automatic int xfer_len(input req_t kind);
    case (kind)
      REQ_WRITE: return 60;
      REQ_READB: return 81;
      REQ_READW: return 162;
      default:   return 1;
    endcase
  endfunction

  task automatic add_tick(input req_t kind, input logic [7:0] ra, input logic [7:0] wd,
                          input logic s);
    bus_tick_t it;
    it.kind     = kind;
    it.reg_addr = ra;
    it.wr_data  = wd;
    it.sda      = s;
    pending_ticks.push_back(it);
  endtask

  // A request followed by fill ticks; while the transfer runs, some ticks
  // carry requests that the busy core must ignore.
  task automatic add_transfer(input req_t kind, input logic [7:0] ra, input logic [7:0] wd,
                              input int sda_mode, input int fill, input int noise_pct);
    int   n;
    logic s;
    req_t k;
    for (n = 0; n <= fill; n++) begin
      case (sda_mode)
        SDA_HIGH:  s = 1'b1;
        SDA_LOW:   s = 1'b0;
        SDA_SPLIT: s = (n < xfer_len(REQ_READB));
        default:   s = 1'($urandom_range(1));
      endcase
      if (n == 0) begin
        add_tick(kind, ra, wd, s);
      end else begin
        k = REQ_TICK;
        if (n < xfer_len(kind) && $urandom_range(99) < noise_pct) k = req_t'($urandom_range(3));
        add_tick(k, 8'($urandom), 8'($urandom), s);
      end
    end
  endtask

  // Random transfers with random read data; some are cut short so that the
  // next request lands while the core is still busy.
  task automatic add_random_traffic(input int target);
    int   fill;
    req_t k;
    while (pending_ticks.size() < target) begin
      k = req_t'($urandom_range(3));
      if ($urandom_range(99) < 15) fill = $urandom_range(xfer_len(k));
      else fill = xfer_len(k) - 1 + $urandom_range(3);
      add_transfer(k, 8'($urandom), 8'($urandom), SDA_RANDOM, fill, 10);
    end
  endtask

  task automatic wait_drained;
    while (pending_ticks.size() != 0 || expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Slave address write while nothing is in flight.
  task automatic write_slave_addr(input logic [7:0] addr);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    slave_wr_addr = addr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Input driver: presents the oldest pending tick, holding it until taken.
  always @(negedge clk) begin
    if (in_taken) void'(pending_ticks.pop_front());
    if (!in_tvalid || in_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_ticks[0].kind;
        in_tdata  <= {7'b0, pending_ticks[0].sda, pending_ticks[0].wr_data,
                      pending_ticks[0].reg_addr};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: models each accepted tick, then checks each accepted result.
  always @(posedge clk) begin
    bus_level_t lv;
    bus_level_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        i2c_tick(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[16], lv);
        expected_levels.push_back(lv);
      end
      if (out_tvalid && out_tready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("unexpected item", int'(out_tdata), 0);
        end else begin
          want = expected_levels.pop_front();
          if (out_tdata[0] !== want.scl) report_mismatch("scl", out_tdata[0], want.scl);
          if (out_tdata[1] !== want.sda) report_mismatch("sda_out", out_tdata[1], want.sda);
          if (out_tdata[2] !== want.busy) report_mismatch("busy_res", out_tdata[2], want.busy);
          if (out_tdata[3] !== want.done) report_mismatch("done_res", out_tdata[3], want.done);
          if (out_tdata[19:4] !== want.rd) report_mismatch("read_data", out_tdata[19:4], want.rd);
          if (want.done) dones_seen++;
        end
        ticks_checked++;
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    logic [7:0] last_addr;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transfers at the reset slave address.
    add_tick(REQ_TICK, 8'hFF, 8'hFF, 1'b1);
    add_tick(REQ_TICK, 8'h00, 8'h00, 1'b0);
    add_transfer(REQ_WRITE, 8'h00, 8'hFF, SDA_LOW, xfer_len(REQ_WRITE) - 1, 0);
    add_transfer(REQ_WRITE, 8'hFF, 8'h00, SDA_RANDOM, xfer_len(REQ_WRITE) + 1, 40);
    add_transfer(REQ_READB, 8'h80, 8'h5A, SDA_HIGH, xfer_len(REQ_READB), 0);
    // Word read at the top register: the second address wraps to zero.
    add_transfer(REQ_READW, 8'hFF, 8'hA5, SDA_SPLIT, xfer_len(REQ_READW), 0);
    add_transfer(REQ_READB, 8'h01, 8'hFF, SDA_LOW, xfer_len(REQ_READB) + 2, 20);
    wait_drained();

    // Random traffic: sender light and receiver heavy stalls.
    write_slave_addr(8'd0);
    add_random_traffic(RANDOM_TICKS);
    wait_drained();

    // Heavy sender stalls, light receiver stalls.
    send_idle_pct = 80;
    recv_idle_pct = 29;
    write_slave_addr(8'd254);
    add_random_traffic(RANDOM_TICKS);
    wait_drained();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    last_addr = 8'($urandom_range(254));
    write_slave_addr(last_addr);
    add_random_traffic(RANDOM_TICKS);
    wait_drained();

    $display("Checked %0d bus ticks: %0d transfers started, %0d completed.",
             ticks_checked, starts_seen, dones_seen);
    $display("Slave addresses 0x%0h, 0x00, 0xfe and 0x%0h; %0d mismatches.",
             SLAVE_ADDR_RESET, last_addr, mismatch_count);
    if (mismatch_count == 0) begin
      $display("i2c_master_register_access_core test passed");
    end else begin
      $display("i2c_master_register_access_core test failed");
    end
    $finish;
  end

  // Watchdog against a hung stream.
  initial begin
    #5000000;
    $display("Timeout with %0d ticks pending and %0d results outstanding.",
             pending_ticks.size(), expected_levels.size());
    $display("i2c_master_register_access_core test failed");
    $finish;
  end

endmodule
